// File: hw/rtl/atrt_pkg.sv
// shared types and constants for the advertiser report table
`default_nettype none
package atrt_pkg;
    localparam int SLOTS = 8;
    localparam int SLOT_W = $clog2(SLOTS);
    localparam int SVC_BYTES = 16;
    localparam int LEN_W = 5;

    localparam logic [2:0] REG_MATCH_UUID = 3'd0;
    localparam logic [2:0] REG_LOUDEST = 3'd1;
    localparam logic [2:0] REG_QUIETEST = 3'd2;
    localparam logic [2:0] REG_REPORT_EVERY = 3'd3;
    localparam logic [2:0] REG_LOUDER_DB = 3'd4;
    localparam logic [2:0] REG_FORGET = 3'd5;
    localparam logic [2:0] REG_MOVE_HOLD = 3'd6;

    localparam logic REQ_ADVERT = 1'b0;
    localparam logic REQ_TICK = 1'b1;

    typedef struct packed {
        logic [47:0] addr;
        logic [1:0] addr_type;
        logic signed [10:0] avg_x4;
        logic [63:0] svc_low;
        logic [63:0] svc_high;
        logic [LEN_W-1:0] svc_len;
        logic [31:0] reported_at;
        logic signed [7:0] reported_rssi;
        logic reported;
    } t_slot;

    localparam int SLOT_BITS = $bits(t_slot);

    typedef struct packed {
        logic req_type;
        logic [31:0] now_ms;
        logic [47:0] adv_addr;
        logic [1:0] adv_addr_type;
        logic [15:0] adv_uuid;
        logic signed [7:0] adv_rssi;
        logic [63:0] adv_svc_low;
        logic [63:0] adv_svc_high;
        logic [7:0] adv_svc_len;
    } t_req;

    typedef struct packed {
        logic [SLOT_W-1:0] rep_slot;
        logic [47:0] rep_addr;
        logic [1:0] rep_addr_type;
        logic signed [7:0] rep_rssi;
        logic [63:0] rep_svc_low;
        logic [63:0] rep_svc_high;
        logic [LEN_W-1:0] rep_svc_len;
        logic rep_last;
    } t_rep;

    function automatic logic [63:0] keep_bytes(input logic [63:0] v, input logic [4:0] n);
        logic [63:0] m;
        m = '0;
        for (int b = 0; b < 8; b++) begin
            if (5'(b) < n) m[b*8 +: 8] = 8'hFF;
        end
        return v & m;
    endfunction
endpackage
`default_nettype wire

// File: hw/rtl/atrt_if.sv
// valid/ready channel carrying one word
`default_nettype none
interface atrt_req_if;
    logic valid;
    logic ready;
    atrt_pkg::t_req data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

interface atrt_rep_if;
    logic valid;
    logic ready;
    atrt_pkg::t_rep data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

// File: hw/rtl/advert_tracker_report_table.sv
// advertiser table: slot ram, slot scan sequencer and report output
// an accepted advert runs a scan over every slot, then a read and a write back, then returns to
// idle; an advert that fails the id or signal check returns to idle from the scan state
// a tick reads, evaluates and steps for each slot, and may wait on the
// report output register; a report is held until the next due slot or the end of the walk
// throughput: one word at a time, the next word is taken only once the table is back in idle
// reset: synchronous active low; clears used flags, heard times and registers to defaults
// slot payload ram is not cleared; a slot is always written when it is allocated
`default_nettype none
module advert_tracker_report_table (
    input wire logic i_clk,
    input wire logic i_rst_n,
    atrt_req_if.sink i_req,
    atrt_rep_if.source o_rep,
    input wire logic psel,
    input wire logic penable,
    input wire logic pwrite,
    input wire logic [4:0] paddr,
    input wire logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic pready
);
    localparam int SW = atrt_pkg::SLOT_W;
    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_AREAD = 3'd2;
    localparam logic [2:0] ST_AWRITE = 3'd3;
    localparam logic [2:0] ST_TREAD = 3'd4;
    localparam logic [2:0] ST_TEVAL = 3'd5;
    localparam logic [2:0] ST_TOUT = 3'd6;

    logic [15:0] r_match_uuid;
    logic signed [7:0] r_loudest, r_quietest;
    logic [31:0] r_report_every, r_forget, r_move_hold;
    logic [7:0] r_louder_db;

    logic [atrt_pkg::SLOTS-1:0] r_used;
    logic [31:0] r_heard [atrt_pkg::SLOTS];

    logic [2:0] r_state;
    atrt_pkg::t_req r_req;
    logic [SW:0] r_idx;
    logic [SW-1:0] r_sel, r_oldest, r_free;
    logic r_found, r_have_free, r_fresh;

    logic ram_we;
    logic [SW-1:0] ram_waddr, ram_raddr;
    atrt_pkg::t_slot ram_wdata, ram_rdata;

    logic r_rep_valid;
    atrt_pkg::t_rep r_rep;
    logic r_pend_valid;
    atrt_pkg::t_rep r_pend;
    atrt_pkg::t_rep pend_last;

    assign pready = 1'b1;
    wire cfg_we = psel && penable && pwrite;
    wire [2:0] cfg_idx = paddr[4:2];

    always_comb begin
        prdata = '0;
        unique case (cfg_idx)
            atrt_pkg::REG_MATCH_UUID: prdata = {16'd0, r_match_uuid};
            atrt_pkg::REG_LOUDEST: prdata = {{24{r_loudest[7]}}, r_loudest};
            atrt_pkg::REG_QUIETEST: prdata = {{24{r_quietest[7]}}, r_quietest};
            atrt_pkg::REG_REPORT_EVERY: prdata = r_report_every;
            atrt_pkg::REG_LOUDER_DB: prdata = {24'd0, r_louder_db};
            atrt_pkg::REG_FORGET: prdata = r_forget;
            atrt_pkg::REG_MOVE_HOLD: prdata = r_move_hold;
            default: prdata = '0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_match_uuid <= 16'hFFF6;
            r_loudest <= -8'sd15;
            r_quietest <= -8'sd110;
            r_report_every <= 32'd10000;
            r_louder_db <= 8'd6;
            r_forget <= 32'd30000;
            r_move_hold <= 32'd1000;
        end else if (cfg_we) begin
            priority case (cfg_idx)
                atrt_pkg::REG_MATCH_UUID: r_match_uuid <= pwdata[15:0];
                atrt_pkg::REG_LOUDEST: r_loudest <= pwdata[7:0];
                atrt_pkg::REG_QUIETEST: r_quietest <= pwdata[7:0];
                atrt_pkg::REG_REPORT_EVERY: r_report_every <= pwdata;
                atrt_pkg::REG_LOUDER_DB: r_louder_db <= pwdata[7:0];
                atrt_pkg::REG_FORGET: r_forget <= pwdata;
                atrt_pkg::REG_MOVE_HOLD: r_move_hold <= pwdata;
                default: ;
            endcase
        end
    end

    atrt_ram #(.WIDTH(atrt_pkg::SLOT_BITS), .DEPTH(atrt_pkg::SLOTS)) u_slot_ram (
        .i_clk(i_clk), .i_we(ram_we), .i_waddr(ram_waddr), .i_wdata(ram_wdata),
        .i_raddr(ram_raddr), .o_rdata(ram_rdata)
    );

    // address match needs the stored address: keep a small copy in flops
    logic [47:0] r_addr [atrt_pkg::SLOTS];

    wire [SW-1:0] scan_i = r_idx[SW-1:0];
    wire rssi_ok = (r_req.adv_rssi < r_loudest) && !(r_req.adv_rssi < r_quietest);
    wire adv_ok = (r_req.adv_uuid == r_match_uuid) && rssi_ok;

    // advert update arithmetic
    logic [4:0] len_c;
    logic signed [10:0] r4, avg_n;
    logic signed [11:0] diff;
    logic signed [11:0] dq;
    always_comb begin
        len_c = (r_req.adv_svc_len > 8'(atrt_pkg::SVC_BYTES)) ? 5'(atrt_pkg::SVC_BYTES)
              : r_req.adv_svc_len[4:0];
        r4 = 11'(r_req.adv_rssi) <<< 2;
        diff = 12'(r4) - 12'(ram_rdata.avg_x4);
        // truncate toward zero
        dq = (diff + (diff[11] ? 12'sd3 : 12'sd0)) >>> 2;
        avg_n = r_fresh ? r4 : 11'(12'(ram_rdata.avg_x4) + dq);
    end

    // tick evaluation
    logic [31:0] age, since_rep, gap;
    logic signed [7:0] rs;
    logic signed [8:0] d;
    logic [8:0] dabs;
    logic due, stale;
    logic [10:0] av_adj;
    always_comb begin
        age = r_req.now_ms - r_heard[r_sel];
        stale = age > r_forget;
        av_adj = 11'(ram_rdata.avg_x4 + (ram_rdata.avg_x4[10] ? 11'sd3 : 11'sd0));
        rs = 8'(signed'(av_adj) >>> 2);
        since_rep = r_req.now_ms - ram_rdata.reported_at;
        gap = r_heard[r_sel] - ram_rdata.reported_at;
        d = 9'(rs) - 9'(ram_rdata.reported_rssi);
        dabs = d[8] ? 9'(-d) : 9'(d);
        due = !ram_rdata.reported
            || (gap != 32'd0 && !gap[31] && since_rep >= r_report_every)
            || (ram_rdata.reported && dabs >= {1'b0, r_louder_db} && since_rep >= r_move_hold);
    end

    wire out_free = !r_rep_valid || o_rep.ready;
    wire rep_now = r_used[r_sel] && !stale && due;
    // a newly due slot pushes the held report out, so wait until the output register is free
    wire teval_stall = (r_state == ST_TEVAL) && rep_now && r_pend_valid && !out_free;
    wire emit_mid = (r_state == ST_TEVAL) && rep_now && r_pend_valid && out_free;
    wire emit_last = (r_state == ST_TOUT) && (r_sel == SW'(atrt_pkg::SLOTS-1))
                     && r_pend_valid && out_free;

    assign i_req.ready = (r_state == ST_IDLE);
    assign o_rep.valid = r_rep_valid;
    assign o_rep.data = r_rep;

    always_comb begin
        pend_last = r_pend;
        pend_last.rep_last = 1'b1;
    end

    always_comb begin
        ram_we = 1'b0;
        ram_waddr = r_sel;
        ram_raddr = r_sel;
        ram_wdata = ram_rdata;
        if (r_state == ST_AWRITE) begin
            ram_we = 1'b1;
            ram_wdata.addr = r_req.adv_addr;
            ram_wdata.addr_type = r_req.adv_addr_type;
            ram_wdata.avg_x4 = avg_n;
            ram_wdata.svc_len = len_c;
            ram_wdata.svc_low = atrt_pkg::keep_bytes(r_req.adv_svc_low, len_c);
            ram_wdata.svc_high = atrt_pkg::keep_bytes(r_req.adv_svc_high,
                (len_c > 5'd8) ? len_c - 5'd8 : 5'd0);
            if (r_fresh) begin
                ram_wdata.reported_at = '0;
                ram_wdata.reported_rssi = '0;
                ram_wdata.reported = 1'b0;
            end
        end else if (r_state == ST_TEVAL && rep_now && !teval_stall) begin
            ram_we = 1'b1;
            ram_wdata.reported = 1'b1;
            ram_wdata.reported_at = r_req.now_ms;
            ram_wdata.reported_rssi = rs;
        end
    end

    // report output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rep_valid <= 1'b0;
        end else if (emit_mid || emit_last) begin
            r_rep <= emit_last ? pend_last : r_pend;
            r_rep_valid <= 1'b1;
        end else if (o_rep.ready) begin
            r_rep_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_used <= '0;
            r_pend_valid <= 1'b0;
            for (int k = 0; k < atrt_pkg::SLOTS; k++) r_heard[k] <= '0;
        end else begin
            unique case (r_state)
                ST_IDLE: begin
                    if (i_req.valid) begin
                        r_req <= i_req.data;
                        r_idx <= '0;
                        r_found <= 1'b0;
                        r_have_free <= 1'b0;
                        r_oldest <= '0;
                        r_sel <= '0;
                        r_pend_valid <= 1'b0;
                        r_state <= (i_req.data.req_type == atrt_pkg::REQ_TICK) ? ST_TREAD
                                 : ST_SCAN;
                    end
                end
                ST_SCAN: begin
                    if (!adv_ok) begin
                        r_state <= ST_IDLE;
                    end else if (r_idx == (SW+1)'(atrt_pkg::SLOTS)) begin
                        r_sel <= r_found ? r_sel : (r_have_free ? r_free : r_oldest);
                        r_fresh <= !r_found;
                        r_state <= ST_AREAD;
                    end else begin
                        if (!r_found) begin
                            if (r_used[scan_i] && r_addr[scan_i] == r_req.adv_addr) begin
                                r_found <= 1'b1;
                                r_sel <= scan_i;
                            end else begin
                                if (!r_used[scan_i] && !r_have_free) begin
                                    r_have_free <= 1'b1;
                                    r_free <= scan_i;
                                end
                                if (r_heard[scan_i] < r_heard[r_oldest]) r_oldest <= scan_i;
                            end
                        end
                        r_idx <= r_idx + 1'b1;
                    end
                end
                ST_AREAD: r_state <= ST_AWRITE;
                ST_AWRITE: begin
                    r_used[r_sel] <= 1'b1;
                    r_addr[r_sel] <= r_req.adv_addr;
                    r_heard[r_sel] <= r_req.now_ms;
                    r_state <= ST_IDLE;
                end
                ST_TREAD: r_state <= ST_TEVAL;
                ST_TEVAL: begin
                    if (!teval_stall) begin
                        if (r_used[r_sel] && stale) r_used[r_sel] <= 1'b0;
                        if (rep_now) begin
                            r_pend_valid <= 1'b1;
                            r_pend.rep_slot <= r_sel;
                            r_pend.rep_addr <= ram_rdata.addr;
                            r_pend.rep_addr_type <= ram_rdata.addr_type;
                            r_pend.rep_rssi <= rs;
                            r_pend.rep_svc_low <= ram_rdata.svc_low;
                            r_pend.rep_svc_high <= ram_rdata.svc_high;
                            r_pend.rep_svc_len <= ram_rdata.svc_len;
                            r_pend.rep_last <= 1'b0;
                        end
                        r_state <= ST_TOUT;
                    end
                end
                ST_TOUT: begin
                    // held report goes out once the next one is known or the walk ends
                    if (r_sel == SW'(atrt_pkg::SLOTS-1)) begin
                        if (!r_pend_valid) r_state <= ST_IDLE;
                        else if (out_free) begin
                            r_pend_valid <= 1'b0;
                            r_state <= ST_IDLE;
                        end
                    end else begin
                        r_sel <= r_sel + 1'b1;
                        r_state <= ST_TREAD;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_rep.valid && !o_rep.ready |=> o_rep.valid && $stable(o_rep.data))
        else $error("report word changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_AWRITE |=> r_used[$past(r_sel)])
        else $error("allocated slot not marked used");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_req.valid && i_req.ready |=> r_state != ST_IDLE)
        else $error("accepted word did not start work");
endmodule
`default_nettype wire

// File: hw/rtl/atrt_ram.sv
// generic simple dual port ram (separate write and read addresses) with registered read
`default_nettype none
module atrt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input wire logic i_clk,
    input wire logic i_we,
    input wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input wire logic [WIDTH-1:0] i_wdata,
    input wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0] o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];
    always_ff @(posedge i_clk) begin
        if (i_we) r_mem[i_waddr] <= i_wdata;
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

// File: tb/sv/advert_tracker_report_table_tb.sv
// testbench for the advertiser report table: random adverts and ticks against a predictor
`default_nettype none
module advert_tracker_report_table_tb;
    localparam int SW = atrt_pkg::SLOT_W;
    localparam int NS = atrt_pkg::SLOTS;
    localparam int LONG_HOLD_AT = 300;
    localparam int LONG_HOLD_CYCLES = 600;

    logic i_clk;
    logic i_rst_n;
    logic psel, penable, pwrite;
    logic [4:0] paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic pready;

    atrt_req_if req_ch ();
    atrt_rep_if rep_ch ();

    advert_tracker_report_table dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_req(req_ch.sink), .o_rep(rep_ch.source),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    // predictor state
    logic [15:0] cfg_uuid;
    logic signed [7:0] cfg_loud, cfg_quiet;
    logic [31:0] cfg_every, cfg_forget, cfg_hold;
    logic [7:0] cfg_louder;
    logic tab_used [NS];
    logic [47:0] tab_addr [NS];
    logic [1:0] tab_type [NS];
    int tab_avg [NS];
    logic [63:0] tab_lo [NS], tab_hi [NS];
    logic [4:0] tab_len [NS];
    logic [31:0] tab_heard [NS], tab_rep_at [NS];
    int tab_rep_rssi [NS];
    logic tab_rep [NS];

    atrt_pkg::t_req pending_words [$];
    atrt_pkg::t_rep expected_reports [$];
    int errors = 0;
    int idle_cycles = 0;

    task automatic report_mismatch(input string what);
        $display("mismatch: %s", what);
        errors++;
    endtask

    function automatic logic [63:0] mask_bytes(input logic [63:0] v, input int n);
        if (n >= 8) return v;
        if (n <= 0) return 64'd0;
        return v & ((64'd1 << (8 * n)) - 64'd1);
    endfunction

    function automatic void table_reset();
        cfg_uuid = 16'hFFF6; cfg_loud = -8'sd15; cfg_quiet = -8'sd110;
        cfg_every = 32'd10000; cfg_louder = 8'd6; cfg_forget = 32'd30000; cfg_hold = 32'd1000;
        for (int i = 0; i < NS; i++) begin
            tab_used[i] = 0; tab_heard[i] = 0; tab_rep[i] = 0; tab_avg[i] = 0;
            tab_addr[i] = 0; tab_type[i] = 0; tab_lo[i] = 0; tab_hi[i] = 0;
            tab_len[i] = 0; tab_rep_at[i] = 0; tab_rep_rssi[i] = 0;
        end
    endfunction

    function automatic void track_word(input atrt_pkg::t_req w);
        int slot, free_s, oldest, r, len;
        bit fresh;
        slot = -1; free_s = -1; oldest = 0; fresh = 0;
        if (w.req_type == atrt_pkg::REQ_TICK) begin
            int n;
            n = 0;
            for (int i = 0; i < NS; i++) begin
                logic [31:0] since, gap;
                int rs, d;
                bit due;
                atrt_pkg::t_rep e;
                if (!tab_used[i]) continue;
                if (32'(w.now_ms - tab_heard[i]) > cfg_forget) begin
                    tab_used[i] = 0;
                    continue;
                end
                rs = tab_avg[i] / 4;
                since = w.now_ms - tab_rep_at[i];
                gap = tab_heard[i] - tab_rep_at[i];
                d = rs - tab_rep_rssi[i];
                if (d < 0) d = -d;
                due = !tab_rep[i] || (gap != 0 && !gap[31] && since >= cfg_every) ||
                      (tab_rep[i] && d >= int'(cfg_louder) && since >= cfg_hold);
                if (due) begin
                    tab_rep[i] = 1; tab_rep_at[i] = w.now_ms; tab_rep_rssi[i] = rs;
                    e.rep_slot = SW'(i); e.rep_addr = tab_addr[i];
                    e.rep_addr_type = tab_type[i]; e.rep_rssi = 8'(rs);
                    e.rep_svc_low = tab_lo[i]; e.rep_svc_high = tab_hi[i];
                    e.rep_svc_len = tab_len[i]; e.rep_last = 0;
                    expected_reports.push_back(e);
                    n++;
                end
            end
            if (n > 0) expected_reports[$].rep_last = 1;
            return;
        end
        r = int'(w.adv_rssi);
        if (w.adv_uuid != cfg_uuid) return;
        if (r >= int'(cfg_loud) || r < int'(cfg_quiet)) return;
        for (int i = 0; i < NS; i++) begin
            if (tab_used[i] && tab_addr[i] == w.adv_addr) begin
                slot = i;
                break;
            end
            if (!tab_used[i] && free_s < 0) free_s = i;
            if (tab_heard[i] < tab_heard[oldest]) oldest = i;
        end
        if (slot < 0) begin
            slot = free_s >= 0 ? free_s : oldest;
            tab_rep[slot] = 0; tab_rep_at[slot] = 0; tab_rep_rssi[slot] = 0;
            tab_used[slot] = 1; tab_addr[slot] = w.adv_addr;
            fresh = 1;
        end
        tab_type[slot] = w.adv_addr_type;
        if (fresh) tab_avg[slot] = r * 4;
        else tab_avg[slot] = tab_avg[slot] + (r * 4 - tab_avg[slot]) / 4;
        len = (int'(w.adv_svc_len) > atrt_pkg::SVC_BYTES) ? atrt_pkg::SVC_BYTES
            : int'(w.adv_svc_len);
        tab_len[slot] = 5'(len);
        tab_lo[slot] = mask_bytes(w.adv_svc_low, len);
        tab_hi[slot] = mask_bytes(w.adv_svc_high, len > 8 ? len - 8 : 0);
        tab_heard[slot] = w.now_ms;
    endfunction

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    // sender: bursts and gaps
    int burst_left = 0, gap_left = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_ch.valid <= 0;
            req_ch.data <= '0;
        end else begin
            if (req_ch.valid && req_ch.ready) begin
                track_word(req_ch.data);
                void'(pending_words.pop_front());
            end
            if (req_ch.valid && !req_ch.ready) begin
                // keep offering
            end else if (gap_left > 0) begin
                gap_left <= gap_left - 1;
                req_ch.valid <= 0;
            end else if (pending_words.size() > 0) begin
                req_ch.valid <= 1;
                req_ch.data <= pending_words[0];
                if (burst_left <= 1) begin
                    burst_left <= $urandom_range(1, 12);
                    gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 20);
                end else begin
                    burst_left <= burst_left - 1;
                end
            end else begin
                req_ch.valid <= 0;
            end
        end
    end

    // receiver: stall pattern, plus one long hold-off while words keep coming
    int stall_phase = 0;
    int seen_words = 0;
    int hold_left = 0;
    bit held_once = 0;
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            rep_ch.ready <= 0;
        end else begin
            stall_phase <= stall_phase + 1;
            if (req_ch.valid && req_ch.ready) seen_words <= seen_words + 1;
            if (!held_once && seen_words == LONG_HOLD_AT) begin
                held_once <= 1;
                hold_left <= LONG_HOLD_CYCLES;
            end else if (hold_left > 0) begin
                hold_left <= hold_left - 1;
            end
            if (hold_left > 0) rep_ch.ready <= 0;
            else if (stall_phase[8]) rep_ch.ready <= 1;
            else rep_ch.ready <= ($urandom_range(0, 3) != 0);
        end
    end

    // monitor
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (rep_ch.valid && rep_ch.ready) begin
                if (expected_reports.size() == 0) begin
                    report_mismatch("report with none expected");
                end else begin
                    atrt_pkg::t_rep e, g;
                    e = expected_reports.pop_front();
                    g = rep_ch.data;
                    if (g.rep_slot != e.rep_slot) report_mismatch("rep_slot");
                    if (g.rep_addr != e.rep_addr) report_mismatch("rep_addr");
                    if (g.rep_addr_type != e.rep_addr_type) report_mismatch("rep_addr_type");
                    if (g.rep_rssi != e.rep_rssi) report_mismatch("rep_rssi");
                    if (g.rep_svc_low != e.rep_svc_low) report_mismatch("rep_svc_low");
                    if (g.rep_svc_high != e.rep_svc_high) report_mismatch("rep_svc_high");
                    if (g.rep_svc_len != e.rep_svc_len) report_mismatch("rep_svc_len");
                    if (g.rep_last != e.rep_last) report_mismatch("rep_last");
                end
            end
            if ((req_ch.valid && req_ch.ready) || (rep_ch.valid && rep_ch.ready) || psel)
                idle_cycles <= 0;
            else
                idle_cycles <= idle_cycles + 1;
        end
    end

    always @(posedge i_clk) begin
        if (idle_cycles > 20000) begin
            $display("TB_ERROR");
            $finish;
        end
    end

    // write a register, then read it back
    task automatic reg_write(input logic [2:0] idx, input logic [31:0] val);
        logic [31:0] want;
        @(posedge i_clk);
        psel <= 1; penable <= 0; pwrite <= 1; paddr <= {idx, 2'b00}; pwdata <= val;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        penable <= 0; pwrite <= 0;
        @(posedge i_clk);
        penable <= 1;
        @(posedge i_clk);
        case (idx)
            atrt_pkg::REG_MATCH_UUID: want = {16'd0, val[15:0]};
            atrt_pkg::REG_LOUDEST: want = {{24{val[7]}}, val[7:0]};
            atrt_pkg::REG_QUIETEST: want = {{24{val[7]}}, val[7:0]};
            atrt_pkg::REG_LOUDER_DB: want = {24'd0, val[7:0]};
            default: want = val;
        endcase
        if (!pready) report_mismatch("pready");
        if (prdata != want) report_mismatch("register readback");
        psel <= 0; penable <= 0; pwrite <= 0;
        case (idx)
            atrt_pkg::REG_MATCH_UUID: cfg_uuid = val[15:0];
            atrt_pkg::REG_LOUDEST: cfg_loud = val[7:0];
            atrt_pkg::REG_QUIETEST: cfg_quiet = val[7:0];
            atrt_pkg::REG_REPORT_EVERY: cfg_every = val;
            atrt_pkg::REG_LOUDER_DB: cfg_louder = val[7:0];
            atrt_pkg::REG_FORGET: cfg_forget = val;
            atrt_pkg::REG_MOVE_HOLD: cfg_hold = val;
            default: ;
        endcase
    endtask

    task automatic drain();
        int guard;
        guard = 0;
        while ((pending_words.size() > 0 || req_ch.valid || expected_reports.size() > 0)
               && guard < 200000) begin
            @(posedge i_clk);
            guard++;
        end
        repeat (40) @(posedge i_clk);
    endtask

    // addresses from a small pool so slots get revisited and evicted
    logic [47:0] addr_pool [12];
    logic [31:0] clock_ms;

    function automatic atrt_pkg::t_req make_advert(input bit good);
        atrt_pkg::t_req w;
        int lo, hi;
        w.req_type = atrt_pkg::REQ_ADVERT;
        clock_ms = clock_ms + $urandom_range(0, 3000);
        w.now_ms = clock_ms;
        w.adv_addr = ($urandom_range(0, 9) == 0) ? 48'({$urandom, $urandom}) :
                     addr_pool[$urandom_range(0, 11)];
        w.adv_addr_type = 2'($urandom);
        w.adv_uuid = (good || $urandom_range(0, 1)) ? cfg_uuid : 16'($urandom);
        lo = int'(cfg_quiet); hi = int'(cfg_loud) - 1;
        if (good && hi >= lo) w.adv_rssi = 8'($urandom_range(hi - lo, 0) + lo);
        else w.adv_rssi = 8'($urandom);
        w.adv_svc_low = {$urandom, $urandom};
        w.adv_svc_high = {$urandom, $urandom};
        w.adv_svc_len = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 17));
        return w;
    endfunction

    function automatic atrt_pkg::t_req make_tick();
        atrt_pkg::t_req w;
        w = '0;
        w.req_type = atrt_pkg::REQ_TICK;
        clock_ms = clock_ms + $urandom_range(0, 4000);
        if ($urandom_range(0, 30) == 0) clock_ms = clock_ms + 40000;
        w.now_ms = clock_ms;
        w.adv_addr = 48'({$urandom, $urandom});
        w.adv_svc_low = {$urandom, $urandom};
        w.adv_svc_high = {$urandom, $urandom};
        w.adv_svc_len = 8'($urandom);
        w.adv_rssi = 8'($urandom);
        w.adv_uuid = 16'($urandom);
        w.adv_addr_type = 2'($urandom);
        return w;
    endfunction

    initial begin
        atrt_pkg::t_req w;
        i_rst_n = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = 0; pwdata = 0;
        req_ch.valid = 0; req_ch.data = '0;
        rep_ch.ready = 0;
        table_reset();
        clock_ms = 32'hFFFF_0000;
        for (int i = 0; i < 12; i++) addr_pool[i] = 48'({$urandom, $urandom});
        addr_pool[0] = '0;
        addr_pool[1] = '1;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: edges of rssi window, payload lengths, move, wrap
        for (int i = 0; i < 10; i++) begin
            w = make_advert(1);
            w.adv_addr = addr_pool[i];
            case (i)
                0: begin w.adv_rssi = -8'sd110; w.adv_svc_len = 8'd0; end
                1: begin w.adv_rssi = -8'sd16; w.adv_svc_len = 8'd255; end
                2: begin w.adv_rssi = -8'sd15; end
                3: begin w.adv_rssi = -8'sd111; end
                4: begin w.adv_rssi = 8'sd127; w.adv_svc_len = 8'd8; end
                5: begin w.adv_rssi = 8'h80; w.adv_svc_len = 8'd9; end
                default: w.adv_svc_len = 8'd16;
            endcase
            pending_words.push_back(w);
        end
        pending_words.push_back(make_tick());
        w = make_advert(1); w.adv_addr = addr_pool[0]; w.adv_rssi = -8'sd20;
        pending_words.push_back(w);
        w = make_advert(1); w.adv_uuid = ~cfg_uuid;
        pending_words.push_back(w);
        clock_ms = clock_ms + 2000;
        pending_words.push_back(make_tick());
        clock_ms = clock_ms + 12000;
        pending_words.push_back(make_tick());
        clock_ms = clock_ms + 50000;
        pending_words.push_back(make_tick());
        drain();

        // phases of register settings, extremes included
        for (int ph = 0; ph < 5; ph++) begin
            case (ph)
                0: begin
                    reg_write(atrt_pkg::REG_MATCH_UUID, 32'h0000);
                    reg_write(atrt_pkg::REG_LOUDEST, 32'h00);
                    reg_write(atrt_pkg::REG_QUIETEST, 32'h80);
                    reg_write(atrt_pkg::REG_REPORT_EVERY, 32'd0);
                    reg_write(atrt_pkg::REG_LOUDER_DB, 32'd0);
                    reg_write(atrt_pkg::REG_FORGET, 32'hFFFF_FFFF);
                    reg_write(atrt_pkg::REG_MOVE_HOLD, 32'd0);
                end
                1: begin
                    reg_write(atrt_pkg::REG_MATCH_UUID, 32'hFFFF);
                    reg_write(atrt_pkg::REG_LOUDEST, 32'hF0);
                    reg_write(atrt_pkg::REG_QUIETEST, 32'hB0);
                    reg_write(atrt_pkg::REG_REPORT_EVERY, 32'hFFFF_FFFF);
                    reg_write(atrt_pkg::REG_LOUDER_DB, 32'd255);
                    reg_write(atrt_pkg::REG_FORGET, 32'd0);
                    reg_write(atrt_pkg::REG_MOVE_HOLD, 32'hFFFF_FFFF);
                end
                default: begin
                    reg_write(atrt_pkg::REG_MATCH_UUID, $urandom);
                    reg_write(atrt_pkg::REG_LOUDEST, 32'($urandom_range(0, 127)) ^ 32'hFF);
                    reg_write(atrt_pkg::REG_QUIETEST, 32'hFF - 32'($urandom_range(80, 127)));
                    reg_write(atrt_pkg::REG_REPORT_EVERY, $urandom_range(0, 8000));
                    reg_write(atrt_pkg::REG_LOUDER_DB, $urandom_range(0, 10));
                    reg_write(atrt_pkg::REG_FORGET, $urandom_range(2000, 40000));
                    reg_write(atrt_pkg::REG_MOVE_HOLD, $urandom_range(0, 3000));
                end
            endcase
            for (int k = 0; k < 100; k++) begin
                if ($urandom_range(0, 3) == 0) pending_words.push_back(make_tick());
                else pending_words.push_back(make_advert($urandom_range(0, 4) != 0));
            end
            drain();
        end

        if (errors == 0 && expected_reports.size() == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end
endmodule
`default_nettype wire

// File: sim.f
hw/rtl/atrt_pkg.sv
hw/rtl/atrt_if.sv
hw/rtl/atrt_ram.sv
hw/rtl/advert_tracker_report_table.sv
tb/sv/advert_tracker_report_table_tb.sv
